>>> src/fvn_pkg.sv
package fvn_pkg;

    // hash mix constants
    localparam logic [31:0] HASH_MUL_X = 32'h27d4eb2f;
    localparam logic [31:0] HASH_MUL_Y = 32'h165667b1;
    localparam logic [31:0] HASH_MIX_A = 32'h85ebca6b;
    localparam logic [31:0] HASH_MIX_B = 32'hc2b2ae35;

    // seed of octave o is kind * SEED_MUL + 1 + o * SEED_OCTAVE_STEP
    localparam logic [12:0] SEED_MUL         = 13'd7919;
    localparam logic [31:0] SEED_OCTAVE_STEP = 32'd101;

    localparam logic [15:0] NOISE_SCALE_RESET = 16'd11796;

    // smoothstep numerator term 3 * 2^16, and one in Q1.16
    localparam logic [17:0] EASE_THREE = 18'd196608;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    // variant thresholds on the octave sum in units of 2^-56
    localparam logic [57:0] VAR_THR_1 = 58'd3 << 54;
    localparam logic [57:0] VAR_THR_2 = 58'd6 << 54;
    localparam logic [57:0] VAR_THR_3 = 58'd9 << 54;

    typedef enum logic [1:0] {
        VAR_PLAIN  = 2'd0,
        VAR_HFLIP  = 2'd1,
        VAR_VFLIP  = 2'd2,
        VAR_HVFLIP = 2'd3
    } variant_t;

endpackage

>>> src/fractal_value_noise_variant_core.sv
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------
// in       | in_valid / in_ready    | terrain_index, tile_column, tile_row
// out      | out_valid / out_ready  | variant
// cfg      | cfg_valid / cfg_ready  | cfg_data (noise_scale, Q0.16)
//
// one tile per cycle sustained while out_ready is high; seven register
// stages from an input transaction to its variant (scale, three hash
// multiplies, row blend, column blend, threshold compare)
// all stages advance together while the output register is empty or taken,
// so a stall holds every stage in place
// rst_n clears the valid bits and loads noise_scale with its default
// cfg_ready is always high; write only while the pipe is empty
module fractal_value_noise_variant_core #(
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  terrain_index,
    input  logic [15:0] tile_column,
    input  logic [15:0] tile_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  variant,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import fvn_pkg::*;

    // coordinates wider than the ports are already masked by the port width
    localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;

    logic        pipe_en;
    logic [6:0]  vld_reg;
    logic [15:0] scale_reg;

    // stage 1: scaled positions and base seed
    logic [15:0] col_m, row_m;
    logic [31:0] px_reg, py_reg, seed_reg;

    // octave positions, lattice corners and fractions
    logic [32:0] posx [2];
    logic [32:0] posy [2];
    logic [31:0] x0 [2];
    logic [31:0] y0 [2];
    logic [31:0] oseed [2];
    logic [23:0] n00 [2];
    logic [23:0] n10 [2];
    logic [23:0] n01 [2];
    logic [23:0] n11 [2];
    logic [15:0] sx [2];
    logic [15:0] sy [2];

    // stage 5 and 6: row blends, octave values
    logic [39:0] r0_reg [2];
    logic [39:0] r1_reg [2];
    logic [15:0] sy_reg [2];
    logic [55:0] v_reg [2];
    logic [57:0] sum;
    variant_t    var_next;
    variant_t    var_reg;

    assign pipe_en   = !vld_reg[6] || out_ready;
    assign in_ready  = pipe_en;
    assign out_valid = vld_reg[6];
    assign variant   = var_reg;
    assign cfg_ready = 1'b1;

    assign col_m = 16'(tile_column[CW-1:0]);
    assign row_m = 16'(tile_row[CW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            scale_reg <= NOISE_SCALE_RESET;
        end
        else
        begin
            if (pipe_en)
                vld_reg <= {vld_reg[5:0], in_valid};
            if (cfg_valid && cfg_ready)
                scale_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            px_reg   <= 32'(col_m) * 32'(scale_reg);
            py_reg   <= 32'(row_m) * 32'(scale_reg);
            seed_reg <= 32'(terrain_index * SEED_MUL) + 32'd1;
        end
    end

    // octave 1 sees doubled positions and a stepped seed
    always_comb
    begin
        posx[0]  = {1'b0, px_reg};
        posy[0]  = {1'b0, py_reg};
        posx[1]  = {px_reg, 1'b0};
        posy[1]  = {py_reg, 1'b0};
        oseed[0] = seed_reg;
        oseed[1] = seed_reg + SEED_OCTAVE_STEP;
        for (int o = 0; o < 2; o++)
        begin
            x0[o] = 32'(posx[o][32:16]);
            y0[o] = 32'(posy[o][32:16]);
        end
    end

    // stages 2 to 4: corner hashes and smoothstep weights
    for (genvar o = 0; o < 2; o++)
    begin : g_oct
        fvn_corner_hash u_h00 (.clk(clk), .en(pipe_en), .x(x0[o]), .y(y0[o]),
                               .seed(oseed[o]), .value(n00[o]));
        fvn_corner_hash u_h10 (.clk(clk), .en(pipe_en), .x(x0[o] + 32'd1), .y(y0[o]),
                               .seed(oseed[o]), .value(n10[o]));
        fvn_corner_hash u_h01 (.clk(clk), .en(pipe_en), .x(x0[o]), .y(y0[o] + 32'd1),
                               .seed(oseed[o]), .value(n01[o]));
        fvn_corner_hash u_h11 (.clk(clk), .en(pipe_en), .x(x0[o] + 32'd1),
                               .y(y0[o] + 32'd1), .seed(oseed[o]), .value(n11[o]));
        fvn_ease u_ex (.clk(clk), .en(pipe_en), .t(posx[o][15:0]), .s(sx[o]));
        fvn_ease u_ey (.clk(clk), .en(pipe_en), .t(posy[o][15:0]), .s(sy[o]));
    end

    // stage 5: blend along x; stage 6: blend along y
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int o = 0; o < 2; o++)
            begin
                r0_reg[o] <= 40'(41'(n00[o]) * 41'(ONE_Q16 - 17'(sx[o]))
                               + 41'(n10[o]) * 41'(sx[o]));
                r1_reg[o] <= 40'(41'(n01[o]) * 41'(ONE_Q16 - 17'(sx[o]))
                               + 41'(n11[o]) * 41'(sx[o]));
                sy_reg[o] <= sy[o];
                v_reg[o]  <= 56'(57'(r0_reg[o]) * 57'(ONE_Q16 - 17'(sy_reg[o]))
                               + 57'(r1_reg[o]) * 57'(sy_reg[o]));
            end
        end
    end

    // stage 7: octave sum against the variant thresholds
    always_comb
    begin
        sum = {1'b0, v_reg[0], 1'b0} + 58'(v_reg[1]);
        if (sum >= VAR_THR_3)
            var_next = VAR_HVFLIP;
        else if (sum >= VAR_THR_2)
            var_next = VAR_VFLIP;
        else if (sum >= VAR_THR_1)
            var_next = VAR_HFLIP;
        else
            var_next = VAR_PLAIN;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            var_reg <= var_next;
    end

`ifndef SYNTHESIS
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipe");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg == 7'd0 && !(in_valid && in_ready)) |=> !out_valid)
        else $error("result appeared from an empty pipe");
`endif

endmodule

>>> src/fvn_corner_hash.sv
module fvn_corner_hash (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] x,
    input  logic [31:0] y,
    input  logic [31:0] seed,
    output logic [23:0] value
);
    import fvn_pkg::*;

    logic [31:0] mx_reg, my_reg, seed_reg;
    logic [31:0] m1_reg, m2_reg;
    logic [31:0] h0, a0, b0;

    always_comb
    begin
        h0 = seed_reg ^ mx_reg ^ my_reg;
        a0 = h0 ^ (h0 >> 15);
        b0 = m1_reg ^ (m1_reg >> 13);
    end

    // three stages of truncated multiplies: x and y, then mix A, then mix B
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= x * HASH_MUL_X;
            my_reg   <= y * HASH_MUL_Y;
            seed_reg <= seed;
            m1_reg   <= a0 * HASH_MIX_A;
            m2_reg   <= b0 * HASH_MIX_B;
        end
    end

    // low 24 bits of h ^ (h >> 16)
    assign value = m2_reg[23:0] ^ {8'd0, m2_reg[31:16]};

endmodule

>>> src/fvn_ease.sv
module fvn_ease (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] t,
    output logic [15:0] s
);
    import fvn_pkg::*;

    logic [31:0] tt_reg;
    logic [17:0] w_reg;
    logic [49:0] prod_reg;
    logic [15:0] s_reg;
    logic [49:0] prod_next;

    assign prod_next = 50'(tt_reg) * 50'(w_reg);

    // t*t and 3 - 2t, then the product, then the truncated result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt_reg   <= 32'(t) * 32'(t);
            w_reg    <= EASE_THREE - {1'b0, t, 1'b0};
            prod_reg <= prod_next;
            s_reg    <= prod_reg[47:32];
        end
    end

    assign s = s_reg;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import fvn_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  terrain_index;
    logic [15:0] tile_column;
    logic [15:0] tile_row;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  variant;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // predictor copy of the scale register
    logic [15:0] scale_shadow;
    // expected variants, oldest first
    variant_t    variant_queue[$];
    int          error_count;
    int          checked_count;

    fractal_value_noise_variant_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .terrain_index (terrain_index),
        .tile_column   (tile_column),
        .tile_row      (tile_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .variant       (variant),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
            error_count++;
        end
    endtask

    // 32-bit multiply and xorshift mix of one lattice corner, low 24 bits kept
    function automatic logic [23:0] lattice_value(input logic [31:0] cx, input logic [31:0] cy,
                                                  input logic [31:0] seed);
        logic [31:0] h;
        begin
            h = seed ^ (cx * HASH_MUL_X) ^ (cy * HASH_MUL_Y);
            h = (h ^ (h >> 15)) * HASH_MIX_A;
            h = (h ^ (h >> 13)) * HASH_MIX_B;
            h = h ^ (h >> 16);
            return h[23:0];
        end
    endfunction

    // smoothstep of a q0.16 fraction, truncated
    function automatic logic [63:0] smooth_weight(input logic [63:0] t);
        begin
            return (t * t * (64'd196608 - 2 * t)) >> 32;
        end
    endfunction

    // bilinear noise at a q32.16 position, q0.56 result
    function automatic logic [63:0] octave_noise(input logic [63:0] px, input logic [63:0] py,
                                                 input logic [31:0] seed);
        logic [31:0] x0, y0;
        logic [63:0] sx, sy, r0, r1;
        begin
            x0 = px[47:16];
            y0 = py[47:16];
            sx = smooth_weight({48'd0, px[15:0]});
            sy = smooth_weight({48'd0, py[15:0]});
            r0 = lattice_value(x0, y0, seed) * (64'd65536 - sx)
               + lattice_value(x0 + 1, y0, seed) * sx;
            r1 = lattice_value(x0, y0 + 1, seed) * (64'd65536 - sx)
               + lattice_value(x0 + 1, y0 + 1, seed) * sx;
            return r0 * (64'd65536 - sy) + r1 * sy;
        end
    endfunction

    function automatic variant_t tile_variant(input logic [7:0] kind, input logic [15:0] col,
                                              input logic [15:0] row);
        logic [63:0] px, py, total;
        logic [31:0] seed;
        begin
            px = col * scale_shadow;
            py = row * scale_shadow;
            seed = kind * 32'd7919 + 32'd1;
            total = 2 * octave_noise(px, py, seed)
                  + octave_noise(2 * px, 2 * py, seed + SEED_OCTAVE_STEP);
            if (total >= 64'(VAR_THR_3))
                return VAR_HVFLIP;
            else if (total >= 64'(VAR_THR_2))
                return VAR_VFLIP;
            else if (total >= 64'(VAR_THR_1))
                return VAR_HFLIP;
            return VAR_PLAIN;
        end
    endfunction

    // result checker with random output stalls
    initial
    begin
        int stall;
        variant_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 2) == 0)
                stall = 0;
            out_ready = 1'b0;
            repeat (stall) @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            if (variant_queue.size() == 0)
                report_mismatch("variant with no transaction pending");
            else
            begin
                want = variant_queue.pop_front();
                checked_count++;
                if (variant !== want)
                    report_mismatch($sformatf("variant %0d, want %0d", variant, want));
            end
        end
    end

    // valid stays high into the next transaction unless a gap comes first
    task automatic send_tile(input logic [7:0] kind, input logic [15:0] col,
                             input logic [15:0] row, input bit gaps);
        int gap;
        begin
            gap = gaps ? $urandom_range(0, 15) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid      <= 1'b1;
            terrain_index <= kind;
            tile_column   <= col;
            tile_row      <= row;
            do @(posedge clk); while (!in_ready);
            variant_queue.push_back(tile_variant(kind, col, row));
            @(negedge clk);
        end
    endtask

    task automatic drain_pipe;
        begin
            in_valid <= 1'b0;
            while (variant_queue.size() != 0)
                @(negedge clk);
            repeat (12) @(negedge clk);
        end
    endtask

    // scale write while idle
    task automatic write_scale(input logic [15:0] value);
        begin
            drain_pipe();
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            do @(posedge clk); while (!cfg_ready);
            scale_shadow = value;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic test_directed;
        begin
            send_tile(8'd0, 16'd0, 16'd0, 1'b0);
            send_tile(8'd255, 16'hffff, 16'hffff, 1'b0);
            send_tile(8'd0, 16'hffff, 16'd0, 1'b0);
            send_tile(8'd255, 16'd0, 16'hffff, 1'b0);
            send_tile(8'haa, 16'h5555, 16'haaaa, 1'b0);
            send_tile(8'h55, 16'haaaa, 16'h5555, 1'b0);
            write_scale(16'hffff);
            send_tile(8'd1, 16'hffff, 16'hffff, 1'b0);
            send_tile(8'd7, 16'd1, 16'd1, 1'b0);
            write_scale(16'd1);
            send_tile(8'd3, 16'hffff, 16'h8000, 1'b0);
            send_tile(8'd3, 16'd1, 16'd0, 1'b0);
            // zero scale puts every position at the origin
            write_scale(16'd0);
            send_tile(8'd9, 16'h1234, 16'hffff, 1'b0);
            send_tile(8'd200, 16'hffff, 16'hffff, 1'b0);
        end
    endtask

    task automatic test_random(input logic [15:0] value, input int count);
        begin
            write_scale(value);
            for (int i = 0; i < count; i++)
            begin
                send_tile(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), i % 100 >= 50);
                // at the halfway point the sender holds off until all results are in
                if (i == count / 2)
                    drain_pipe();
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        terrain_index = '0;
        tile_column   = '0;
        tile_row      = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        error_count   = 0;
        checked_count = 0;
        scale_shadow  = NOISE_SCALE_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_tile(8'd17, 16'd100, 16'd200, 1'b0);
        test_directed();
        test_random(NOISE_SCALE_RESET, 300);
        test_random(16'hffff, 200);
        test_random(16'd1, 100);
        test_random(16'($urandom_range(1, 65535)), 250);
        test_random(16'd0, 50);
        test_random(16'h8000, 150);
        drain_pipe();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
